[hdl/wbf_pkg.sv]
// Shared types and constants for the wraparound box filter.
// Used by wbf_ctrl, wbf_dp and wraparound_box_filter_2d.
`default_nettype none

package wbf_pkg;

  // Fixed field widths.
  localparam int unsigned HEIGHT_W  = 16;
  localparam int unsigned ROWCOL_W  = 6;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned RADIUS_W  = 3;
  localparam int unsigned WIN_CNT_W = RADIUS_W + 1;
  localparam int unsigned OUT_W     = 24;
  localparam int unsigned FRAC_W    = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_ROWS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_COLS   = 2'd2;

  // Input word action codes.
  typedef enum logic {
    ACT_WRITE = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRAP,
    ST_WRITE,
    ST_REWIND,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_INIT,
    ST_DIV,
    ST_PUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic wrap;
    logic write;
    logic rewind;
    logic scan;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_query;
    logic rewind_done;
    logic scan_last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

[hdl/wbf_ctrl.sv]
// Controller state machine for the wraparound box filter.
// Depends on wbf_pkg; drives commands into wbf_dp and reads its status.
`default_nettype none

module wbf_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  wbf_pkg::sts_t sts_i,
  output wbf_pkg::cmd_t cmd_o
);
  import wbf_pkg::*;

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_WRAP;
        end
      end
      ST_WRAP: begin
        cmd_o.wrap = 1'b1;
        state_d    = sts_i.is_query ? ST_REWIND : ST_WRITE;
      end
      ST_WRITE: begin
        cmd_o.write = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_REWIND: begin
        if (sts_i.rewind_done) begin
          state_d = ST_SCAN;
        end else begin
          cmd_o.rewind = 1'b1;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_last) begin
          state_d = ST_DRAIN;
        end
      end
      // Let the last read word reach the accumulator.
      ST_DRAIN: begin
        state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_PUT;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_PUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/wbf_dp.sv]
// Datapath for the wraparound box filter: config registers, height memory,
// window cursors, accumulator, bit-serial divider and output register.
// Depends on wbf_pkg; sequenced by wbf_ctrl.
`default_nettype none

module wbf_dp #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wbf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          action_i,
  input  logic [wbf_pkg::ROWCOL_W-1:0]  row_i,
  input  logic [wbf_pkg::ROWCOL_W-1:0]  col_i,
  input  logic [wbf_pkg::HEIGHT_W-1:0]  height_i,
  input  wbf_pkg::cmd_t                 cmd_i,
  output wbf_pkg::sts_t                 sts_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [wbf_pkg::OUT_W-1:0]     filtered_o
);
  import wbf_pkg::*;

  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned RCW0  = $clog2(MAX_ROWS + 1);
  localparam int unsigned CCW0  = $clog2(MAX_COLS + 1);
  localparam int unsigned RCW   = (RCW0 > CFG_W) ? RCW0 : CFG_W;
  localparam int unsigned CCW   = (CCW0 > CFG_W) ? CCW0 : CFG_W;
  localparam int unsigned MCW   = (RCW > CCW) ? RCW : CCW;
  localparam int unsigned MW    = MCW + ROWCOL_W;
  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RAD_LIM = (MAX_RADIUS < 7) ? MAX_RADIUS : 7;
  localparam int unsigned WIN_MAX = 2 * RAD_LIM + 1;
  localparam int unsigned N_W   = $clog2(WIN_MAX * WIN_MAX + 1);
  localparam int unsigned SUM_W = HEIGHT_W + N_W;
  localparam int unsigned DV_W  = SUM_W + FRAC_W;
  localparam int unsigned DCW   = $clog2(DV_W + 1);

  // Reduce a 6-bit index modulo m by shift-and-subtract.
  function automatic logic [MW-1:0] wrap_mod(input logic [ROWCOL_W-1:0] v,
                                             input logic [MCW-1:0] m);
    logic [MW-1:0] x;
    logic [MW-1:0] d;
    x = MW'(v);
    for (int s = ROWCOL_W - 1; s >= 0; s--) begin
      d = MW'(m) << s;
      if (x >= d) begin
        x = x - d;
      end
    end
    return x;
  endfunction

  // Configuration registers.
  logic [RADIUS_W-1:0] win_radius_q;
  logic [CFG_W-1:0]    row_count_q;
  logic [CFG_W-1:0]    col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_radius_q <= RADIUS_W'(1);
      row_count_q  <= CFG_W'(64);
      col_count_q  <= CFG_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_IDX_RADIUS: win_radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_IDX_ROWS:   row_count_q  <= cfg_data_i;
        CFG_IDX_COLS:   col_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Clamp counts and radius into their usable ranges.
  logic [RCW-1:0]      nrows;
  logic [CCW-1:0]      ncols;
  logic [RADIUS_W-1:0] rad_eff;

  always_comb begin
    if (row_count_q == '0) begin
      nrows = RCW'(1);
    end else if (RCW'(row_count_q) > RCW'(MAX_ROWS)) begin
      nrows = RCW'(MAX_ROWS);
    end else begin
      nrows = RCW'(row_count_q);
    end
    if (col_count_q == '0) begin
      ncols = CCW'(1);
    end else if (CCW'(col_count_q) > CCW'(MAX_COLS)) begin
      ncols = CCW'(MAX_COLS);
    end else begin
      ncols = CCW'(col_count_q);
    end
    if (32'(win_radius_q) > RAD_LIM) begin
      rad_eff = RADIUS_W'(RAD_LIM);
    end else begin
      rad_eff = win_radius_q;
    end
  end

  // Captured input word.
  logic                 action_q;
  logic [ROWCOL_W-1:0]  row_q;
  logic [ROWCOL_W-1:0]  col_q;
  logic [HEIGHT_W-1:0]  height_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      action_q <= action_i;
      row_q    <= row_i;
      col_q    <= col_i;
      height_q <= height_i;
    end
  end

  // Window cursors and counters.
  logic [RW-1:0]        r_cur_q;
  logic [CW-1:0]        c_cur_q;
  logic [CW-1:0]        c_start_q;
  logic [RADIUS_W-1:0]  rad_q;
  logic [RADIUS_W-1:0]  rew_q;
  logic [WIN_CNT_W-1:0] col_cnt_q;
  logic [WIN_CNT_W-1:0] row_cnt_q;
  logic [N_W-1:0]       n_q;

  logic [RW-1:0]        r_dec, r_inc;
  logic [CW-1:0]        c_dec, c_inc, c_st_dec;
  logic [WIN_CNT_W-1:0] span;
  logic [2*WIN_CNT_W-1:0] n_full;
  logic                 col_end;

  always_comb begin
    r_dec    = (r_cur_q == '0) ? RW'(nrows - RCW'(1)) : r_cur_q - RW'(1);
    r_inc    = ((RCW'(r_cur_q) + RCW'(1)) == nrows) ? '0 : r_cur_q + RW'(1);
    c_dec    = (c_cur_q == '0) ? CW'(ncols - CCW'(1)) : c_cur_q - CW'(1);
    c_inc    = ((CCW'(c_cur_q) + CCW'(1)) == ncols) ? '0 : c_cur_q + CW'(1);
    c_st_dec = (c_start_q == '0) ? CW'(ncols - CCW'(1)) : c_start_q - CW'(1);
    span     = {rad_q, 1'b0};
    n_full   = (2*WIN_CNT_W)'({rad_eff, 1'b1}) * (2*WIN_CNT_W)'({rad_eff, 1'b1});
    col_end  = (col_cnt_q == span);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) begin
      r_cur_q   <= RW'(wrap_mod(row_q, MCW'(nrows)));
      c_cur_q   <= CW'(wrap_mod(col_q, MCW'(ncols)));
      c_start_q <= CW'(wrap_mod(col_q, MCW'(ncols)));
      rad_q     <= rad_eff;
      rew_q     <= rad_eff;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      n_q       <= N_W'(n_full);
    end else if (cmd_i.rewind) begin
      // Step back to the window's top-left corner.
      r_cur_q   <= r_dec;
      c_cur_q   <= c_dec;
      c_start_q <= c_st_dec;
      rew_q     <= rew_q - RADIUS_W'(1);
    end else if (cmd_i.scan) begin
      // Advance along the row, then wrap to the next row.
      if (col_end) begin
        col_cnt_q <= '0;
        c_cur_q   <= c_start_q;
        r_cur_q   <= r_inc;
        row_cnt_q <= row_cnt_q + WIN_CNT_W'(1);
      end else begin
        col_cnt_q <= col_cnt_q + WIN_CNT_W'(1);
        c_cur_q   <= c_inc;
      end
    end
  end

  // Height memory, one port written or read per cycle.
  logic [HEIGHT_W-1:0] mem_q [DEPTH];
  logic [HEIGHT_W-1:0] rd_q;
  logic                rd_vld_q;
  logic [AW-1:0]       addr;

  assign addr = AW'(r_cur_q) * AW'(MAX_COLS) + AW'(c_cur_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      mem_q[addr] <= height_q;
    end
    if (cmd_i.scan) begin
      rd_q <= mem_q[addr];
    end
  end

  // Accumulate the window sum one word per cycle.
  logic [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wrap) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      sum_q <= sum_q + SUM_W'(rd_q);
    end
  end

  // Restoring divider, one quotient bit per cycle.
  logic [DV_W-1:0] dv_q;
  logic [N_W-1:0]  rem_q;
  logic [DCW-1:0]  div_cnt_q;
  logic [N_W:0]    trial;
  logic            q_bit;

  always_comb begin
    trial = {rem_q, dv_q[DV_W-1]};
    q_bit = (trial >= {1'b0, n_q});
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dv_q      <= {sum_q, {FRAC_W{1'b0}}};
      rem_q     <= '0;
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q     <= q_bit ? N_W'(trial - {1'b0, n_q}) : N_W'(trial);
      dv_q      <= {dv_q[DV_W-2:0], q_bit};
      div_cnt_q <= div_cnt_q + DCW'(1);
    end
  end

  // Output register; holds while stalled.
  logic              out_valid_q;
  logic [OUT_W-1:0]  out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= dv_q[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = out_q;

  // Status back to the controller.
  always_comb begin
    sts_o.is_query    = (action_q == ACT_QUERY);
    sts_o.rewind_done = (rew_q == '0);
    sts_o.scan_last   = col_end && (row_cnt_q == span);
    sts_o.div_done    = (div_cnt_q == DCW'(DV_W));
    sts_o.out_free    = !out_valid_q || !out_stall_i;
  end

endmodule

`default_nettype wire

[hdl/wraparound_box_filter_2d.sv]
// Top level of the wraparound box filter over a stored height grid.
// A write passes through the wrap and write states before the next word can be taken.
// A query rewinds to the window corner, reads one memory word per cycle over
// the window, then runs a one-bit-per-cycle divider and waits for the output
// register to be free. Reset clears control and restores the config
// registers; the height memory is not cleared.
`default_nettype none

module wraparound_box_filter_2d #(
  parameter int unsigned MAX_ROWS   = 64,
  parameter int unsigned MAX_COLS   = 64,
  parameter int unsigned MAX_RADIUS = 7
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wbf_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [wbf_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          action_i,
  input  logic [wbf_pkg::ROWCOL_W-1:0]  row_i,
  input  logic [wbf_pkg::ROWCOL_W-1:0]  col_i,
  input  logic [wbf_pkg::HEIGHT_W-1:0]  height_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [wbf_pkg::OUT_W-1:0]     filtered_o
);
  import wbf_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  wbf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Storage, accumulation and division.
  wbf_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .height_i    (height_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .filtered_o  (filtered_o)
  );

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking bench for wraparound_box_filter_2d: stores heights, queries window
// means and checks each against a local model of the grid and registers or a given value.
// Depends on wbf_pkg and the wraparound_box_filter_2d RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import wbf_pkg::*;

  localparam int GRID_DIM       = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 1500;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 300;
  localparam int PHASE_WORDS    = 100;
  localparam int PHASE_MEANS    = 40;
  localparam int NUM_PHASES     = 6;

  typedef enum logic {
    STEP_CFG,
    STEP_WORD
  } step_kind_e;

  typedef struct packed {
    step_kind_e             kind;
    logic [CFG_IDX_W-1:0]   idx;
    logic [CFG_W-1:0]       data;
    action_e                act;
    logic [ROWCOL_W-1:0]    row;
    logic [ROWCOL_W-1:0]    col;
    logic [HEIGHT_W-1:0]    height;
    bit                     typed;
    logic [OUT_W-1:0]       mean;
  } step_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  action_i;
  logic [ROWCOL_W-1:0]   row_i;
  logic [ROWCOL_W-1:0]   col_i;
  logic [HEIGHT_W-1:0]   height_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [OUT_W-1:0]      filtered_o;

  // Local copy of the grid and registers
  logic [HEIGHT_W-1:0]   heights [GRID_DIM*GRID_DIM];
  bit                    written_map [GRID_DIM*GRID_DIM];
  logic [RADIUS_W-1:0]   radius_q = 3'd1;
  logic [CFG_W-1:0]      rows_q   = 7'd64;
  logic [CFG_W-1:0]      cols_q   = 7'd64;

  logic [OUT_W-1:0]      pending_means [$];
  logic [OUT_W-1:0]      want;
  int                    mismatches  = 0;
  int                    idle_cycles = 0;
  int                    tx_idle_pct = 0;
  int                    rx_idle_pct = 0;
  int                    hold_left   = 0;
  logic                  hold_req    = 1'b0;
  bit                    hold_done   = 1'b0;
  step_t                 directed [$];

  logic [CFG_W-1:0] phase_radius [NUM_PHASES] = '{7'd1, 7'd7, 7'd0, 7'd3, 7'd2, 7'd4};
  logic [CFG_W-1:0] phase_rows   [NUM_PHASES] = '{7'd64, 7'd5, 7'd0, 7'd127, 7'd1, 7'd64};
  logic [CFG_W-1:0] phase_cols   [NUM_PHASES] = '{7'd64, 7'd3, 7'd64, 7'd100, 7'd0, 7'd64};

  wraparound_box_filter_2d dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .row_i       (row_i),
    .col_i       (col_i),
    .height_i    (height_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Count zero and oversize values collapse to the grid bounds
  function automatic int eff_count(logic [CFG_W-1:0] v);
    if (v == 0) return 1;
    if (v > GRID_DIM) return GRID_DIM;
    return int'(v);
  endfunction

  function automatic int wrap_to(int v, int m);
    return ((v % m) + m) % m;
  endfunction

  // Mean of the wrapped window around (r0, c0), 8 fraction bits, rounded down
  function automatic logic [OUT_W-1:0] box_mean(int r0, int c0);
    longint sum;
    int nr, nc, rad, span;
    nr  = eff_count(rows_q);
    nc  = eff_count(cols_q);
    rad = int'(radius_q);
    sum = 0;
    for (int k = -rad; k <= rad; k++) begin
      for (int l = -rad; l <= rad; l++) begin
        sum += heights[wrap_to(r0 + k, nr) * GRID_DIM + wrap_to(c0 + l, nc)];
      end
    end
    span = 2 * rad + 1;
    return OUT_W'((sum << FRAC_W) / (span * span));
  endfunction

  // Find a window cell that has never been written, if any
  function automatic bit find_unwritten(int r0, int c0, output int mr, output int mc);
    int nr, nc, rad, rr, cc;
    nr  = eff_count(rows_q);
    nc  = eff_count(cols_q);
    rad = int'(radius_q);
    mr  = 0;
    mc  = 0;
    for (int k = -rad; k <= rad; k++) begin
      for (int l = -rad; l <= rad; l++) begin
        rr = wrap_to(r0 + k, nr);
        cc = wrap_to(c0 + l, nc);
        if (!written_map[rr * GRID_DIM + cc]) begin
          mr = rr;
          mc = cc;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  // Pick a field value that folds back onto index e under modulus m
  function automatic logic [ROWCOL_W-1:0] spread_index(int e, int m);
    return ROWCOL_W'(e + m * $urandom_range((GRID_DIM - 1 - e) / m));
  endfunction

  function automatic logic [HEIGHT_W-1:0] pick_height();
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) return '0;
    if (roll < 20) return '1;
    return HEIGHT_W'($urandom);
  endfunction

  function automatic step_t cfg_step(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    step_t s;
    s      = '0;
    s.kind = STEP_CFG;
    s.idx  = idx;
    s.data = data;
    return s;
  endfunction

  function automatic step_t word_step(action_e act, logic [ROWCOL_W-1:0] r,
                                      logic [ROWCOL_W-1:0] c, logic [HEIGHT_W-1:0] h,
                                      bit typed, logic [OUT_W-1:0] mean);
    step_t s;
    s        = '0;
    s.kind   = STEP_WORD;
    s.act    = act;
    s.row    = r;
    s.col    = c;
    s.height = h;
    s.typed  = typed;
    s.mean   = mean;
    return s;
  endfunction

  // Offer one word after a random gap, hold it until taken, then update the model
  task automatic send_word(input action_e act, input logic [ROWCOL_W-1:0] r,
                           input logic [ROWCOL_W-1:0] c, input logic [HEIGHT_W-1:0] h,
                           input bit typed, input logic [OUT_W-1:0] mean);
    int gap, r0, c0;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < tx_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    row_i      <= r;
    col_i      <= c;
    height_i   <= h;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    r0 = int'(r) % eff_count(rows_q);
    c0 = int'(c) % eff_count(cols_q);
    if (act == ACT_WRITE) begin
      heights[r0 * GRID_DIM + c0]     = h;
      written_map[r0 * GRID_DIM + c0] = 1'b1;
    end else begin
      pending_means.push_back(typed ? mean : box_mean(r0, c0));
    end
    @(negedge clk_i);
  endtask

  // Let the block go idle, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_IDX_RADIUS: radius_q = data[RADIUS_W-1:0];
      CFG_IDX_ROWS:   rows_q   = data;
      CFG_IDX_COLS:   cols_q   = data;
      default: ;
    endcase
  endtask

  // Drive the result stall: random idling, or one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // Compare each taken mean with the oldest expected one
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means.size() == 0) begin
        $display("%0t: filtered word with none expected, expected none, actual %h",
                 $time, filtered_o);
        mismatches++;
      end else begin
        want = pending_means.pop_front();
        if (filtered_o !== want) begin
          $display("%0t: filtered mismatch, expected %h, actual %h", $time, want, filtered_o);
          mismatches++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    int words, means, nr, nc, er, ec, mr, mc, fr, fc;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_IDX_RADIUS;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i   = ACT_WRITE;
    row_i      = '0;
    col_i      = '0;
    height_i   = '0;

    // Directed words: tiny grids, zero and oversize counts, masked radius,
    // windows wider than the grid, addresses beyond the counts, field extremes
    directed = '{
      cfg_step(CFG_IDX_ROWS, 7'd1),
      cfg_step(CFG_IDX_COLS, 7'd0),
      word_step(ACT_WRITE, 6'd63, 6'd63, 16'hFFFF, 1'b0, '0),
      word_step(ACT_QUERY, 6'd0, 6'd0, 16'h0000, 1'b1, 24'hFFFF00),
      word_step(ACT_QUERY, 6'd63, 6'd63, 16'hFFFF, 1'b1, 24'hFFFF00),
      cfg_step(CFG_IDX_RADIUS, 7'h08),
      word_step(ACT_QUERY, 6'd5, 6'd9, 16'h1234, 1'b1, 24'hFFFF00),
      word_step(ACT_WRITE, 6'd17, 6'd42, 16'h0000, 1'b0, '0),
      word_step(ACT_QUERY, 6'd0, 6'd0, 16'h0000, 1'b1, 24'h000000),
      cfg_step(CFG_IDX_RADIUS, 7'd7),
      word_step(ACT_WRITE, 6'd0, 6'd0, 16'h0001, 1'b0, '0),
      word_step(ACT_QUERY, 6'd44, 6'd21, 16'h0000, 1'b1, 24'h000100),
      cfg_step(CFG_IDX_ROWS, 7'd2),
      cfg_step(CFG_IDX_COLS, 7'd2),
      cfg_step(CFG_IDX_RADIUS, 7'd0),
      word_step(ACT_WRITE, 6'd1, 6'd0, 16'h8000, 1'b0, '0),
      word_step(ACT_WRITE, 6'd0, 6'd1, 16'h7FFF, 1'b0, '0),
      word_step(ACT_WRITE, 6'd1, 6'd1, 16'h5555, 1'b0, '0),
      word_step(ACT_QUERY, 6'd1, 6'd0, 16'h0000, 1'b1, 24'h800000),
      word_step(ACT_QUERY, 6'd3, 6'd2, 16'h0000, 1'b1, 24'h800000),
      word_step(ACT_QUERY, 6'd0, 6'd1, 16'h0000, 1'b1, 24'h7FFF00),
      cfg_step(CFG_IDX_RADIUS, 7'd1),
      word_step(ACT_QUERY, 6'd0, 6'd0, 16'hAAAA, 1'b0, '0),
      word_step(ACT_QUERY, 6'd63, 6'd62, 16'h5555, 1'b0, '0),
      cfg_step(CFG_IDX_ROWS, 7'd127),
      cfg_step(CFG_IDX_COLS, 7'd64),
      word_step(ACT_WRITE, 6'd63, 6'd63, 16'hAAAA, 1'b0, '0),
      word_step(ACT_WRITE, 6'd42, 6'd21, 16'h5555, 1'b0, '0)
    };

    // Hold reset, then release on a falling edge
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 28;
    rx_idle_pct <= 76;
    foreach (directed[i]) begin
      if (directed[i].kind == STEP_CFG) begin
        write_reg(directed[i].idx, directed[i].data);
      end else begin
        send_word(directed[i].act, directed[i].row, directed[i].col, directed[i].height,
                  directed[i].typed, directed[i].mean);
      end
    end

    // Random phases, each under its own register setting
    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      write_reg(CFG_IDX_RADIUS, phase_radius[phase]);
      write_reg(CFG_IDX_ROWS, phase_rows[phase]);
      write_reg(CFG_IDX_COLS, phase_cols[phase]);
      if (phase < 2) begin
        tx_idle_pct = 28;
        rx_idle_pct <= 76;
      end else if (phase < 4) begin
        tx_idle_pct = 76;
        rx_idle_pct <= 28;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
      end
      nr    = eff_count(rows_q);
      nc    = eff_count(cols_q);
      fr    = $urandom_range(nr - 1);
      fc    = $urandom_range(nc - 1);
      words = 0;
      means = 0;
      while (words < PHASE_WORDS || means < PHASE_MEANS) begin
        if ($urandom_range(99) < 40) begin
          send_word(ACT_WRITE, ROWCOL_W'($urandom), ROWCOL_W'($urandom), pick_height(),
                    1'b0, '0);
        end else begin
          // Aim most queries near a focus cell so the window fills up quickly
          if ($urandom_range(99) < 80) begin
            er = (fr + $urandom_range(3)) % nr;
            ec = (fc + $urandom_range(3)) % nc;
          end else begin
            er = $urandom_range(nr - 1);
            ec = $urandom_range(nc - 1);
          end
          if (find_unwritten(er, ec, mr, mc)) begin
            send_word(ACT_WRITE, spread_index(mr, nr), spread_index(mc, nc), pick_height(),
                      1'b0, '0);
          end else begin
            send_word(ACT_QUERY, spread_index(er, nr), spread_index(ec, nc),
                      HEIGHT_W'($urandom), 1'b0, '0);
            means++;
          end
        end
        words++;
        // Back up the result side while words keep coming
        if (phase == 1 && words == 60) hold_req <= 1'b1;
        // Pause the sender until every mean is back
        if (phase == 3 && words == 60) begin
          in_valid_i <= 1'b0;
          while (pending_means.size() != 0) @(negedge clk_i);
        end
      end
    end

    // Drain and watch for stray results
    in_valid_i <= 1'b0;
    while (pending_means.size() != 0) @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
